@@ hw/rtl/pearson_correlation_regression_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the correlation and regression block
// Short forms for clocked implications that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PEARSON_CORRELATION_REGRESSION_TOP_ASSERT_SVH
`define PEARSON_CORRELATION_REGRESSION_TOP_ASSERT_SVH

// Same-cycle implication.
`define PCR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define PCR_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/pcr_pkg.sv @@
// ----------------------------------------------------------------------------
// Correlation and regression package
// Shared constants, types and helper functions.
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int CNT_W       = COUNT_BITS + 1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 152;

  localparam logic [63:0] SMASK = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam logic [63:0] SSIGN = 64'd1 << (SAMPLE_BITS - 1);
  localparam logic [63:0] LIM48 = 64'h0000_8000_0000_0000;

  localparam logic [1:0] STAT_NORMAL = 2'd0;
  localparam logic [1:0] STAT_HORIZ  = 2'd1;
  localparam logic [1:0] STAT_VERT   = 2'd2;
  localparam logic [1:0] STAT_SAT    = 2'd3;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_M_NSXX, SQ_M_SX2, SQ_M_NSYY, SQ_M_SY2, SQ_M_NSXY, SQ_M_SXSY,
    SQ_CLASS, SQ_M_PXY, SQ_SQRT, SQ_DIV_R, SQ_DIV_SL, SQ_M_SLX, SQ_ICN,
    SQ_ICM, SQ_ICA, SQ_DIV_IC, SQ_DIV_MY, SQ_OUT
  } seq_state_t;

  typedef enum logic [1:0] {DS_IDLE, DS_RUN, DS_ROUND} ds_state_t;
  typedef enum logic {DS_DIV, DS_SQRT} ds_mode_t;

  typedef struct packed {
    logic     start;
    ds_mode_t mode;
  } ds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  typedef struct packed {
    logic        sat;
    logic [47:0] val;
  } sat_res_t;

  function automatic logic [63:0] sext(input logic [15:0] v);
    logic [63:0] m;
    m = {48'd0, v} & SMASK;
    return (m ^ SSIGN) - SSIGN;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Magnitude plus sign to two's complement, clamped to 48 bits.
  function automatic sat_res_t sat48(input logic [127:0] mag, input logic neg);
    sat_res_t    r;
    logic [63:0] lim;
    logic [63:0] m;
    lim   = neg ? LIM48 : (LIM48 - 64'd1);
    m     = mag[63:0];
    r.sat = 1'b0;
    if ((mag[127:64] != 64'd0) || (mag[63:0] > lim)) begin
      r.sat = 1'b1;
      m     = lim;
    end
    m     = neg ? (64'd0 - m) : m;
    r.val = m[47:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/pearson_correlation_regression_top.sv @@
// ----------------------------------------------------------------------------
// Pearson correlation and least-squares regression
// Streams signed sample pairs and reports r, slope and intercept per set.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle while the block sits idle: each request adds
// x, y, x*x, y*y and x*y into exact sums and bumps the pair count (pairs past
// the full count are dropped). The request marked with tlast closes the set;
// the block then drops in_tready and works out the cross terms, r, slope and
// intercept under a small sequencer that shares one 32x32 multiplier for the
// 64x64 products and one radix-2 divide / square root unit. A vertical line
// or single point skips the multiplies and divides after the cross terms, and
// a horizontal line needs only the divide for the mean of y. When the
// previous result has not been taken yet, the block waits in its output
// state until the output register is free. The result then sits in the
// output register until taken; the next set may begin streaming as soon as
// that register is loaded.
// Results carry corr_r in Q2.30 and slope and intercept with FRAC_BITS
// fraction bits; status in tuser tells normal, horizontal, vertical or point,
// and saturated.
// ----------------------------------------------------------------------------
module pearson_correlation_regression_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] x_value, [31:16] y_value
  input  logic [pcr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,  // last_item
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] corr_r, [79:32] slope, [127:80] intercept, [144:128] pair_count,
  // [151:145] zero
  output logic [pcr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser  // [1:0] status
);

  localparam int SB = pcr_pkg::SAMPLE_BITS;

  pcr_pkg::seq_state_t state_r, state_nxt;

  // Running sums and count.
  logic [63:0] sx_r, sy_r, sxx_r, syy_r, sxy_r;
  logic [pcr_pkg::CNT_W-1:0] n_r;

  // Shared multiplier.
  logic [63:0]  ma, mb;
  logic [31:0]  a_part, b_part;
  logic [63:0]  prod, prod_r;
  logic [1:0]   pk_r;
  logic [2:0]   mcnt_r;
  logic [127:0] acc_r, addend;
  logic         mul_state, mul_done;

  // Working values.
  logic [63:0]  tmp_r, cxx_r, cyy_r, cxy_r, d_r, sl_r;
  logic [127:0] w_r;
  logic         st_r, sat_r;
  logic [31:0]  r_r;
  logic [47:0]  slope_r, icpt_r;
  logic [1:0]   status_r;

  // Output register.
  logic                           out_valid_r;
  logic [pcr_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]                     out_user_r;

  // Divide / root unit.
  pcr_pkg::ds_ctrl_t ds_ctrl;
  pcr_pkg::ds_stat_t ds_stat;
  logic [127:0]      ds_num, ds_res;
  logic [63:0]       ds_den;
  logic              unit_state, started_r;

  logic [63:0] x64, y64, mag_xy, mag_sy;
  logic signed [SB-1:0]   xs, ys;
  logic signed [2*SB-1:0] pxx, pyy, pxy;
  logic [127:0] t1;
  logic         accept, vert, horiz, out_load;
  pcr_pkg::sat_res_t sr;

  pcr_divsqrt u_divsqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ds_ctrl),
    .num    (ds_num),
    .den    (ds_den),
    .stat   (ds_stat),
    .result (ds_res)
  );

  // Per-pair products are narrow, so they stay in the streaming path.
  always_comb begin
    x64 = pcr_pkg::sext(in_tdata[15:0]);
    y64 = pcr_pkg::sext(in_tdata[31:16]);
    xs  = x64[SB-1:0];
    ys  = y64[SB-1:0];
    pxx = xs * xs;
    pyy = ys * ys;
    pxy = xs * ys;
  end

  always_comb begin
    mag_xy = pcr_pkg::mag64(cxy_r);
    mag_sy = pcr_pkg::mag64(sy_r);
    t1     = {64'd0, mag_sy} << pcr_pkg::FRAC_BITS;
    vert   = (cxx_r == 64'd0) || cxx_r[63];
    horiz  = (cyy_r == 64'd0) || cyy_r[63];
    accept = in_tvalid && in_tready;
    mul_done = (mcnt_r == 3'd4);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcr_pkg::SQ_IDLE:   if (accept && in_tlast) state_nxt = pcr_pkg::SQ_M_NSXX;
      pcr_pkg::SQ_M_NSXX: if (mul_done) state_nxt = pcr_pkg::SQ_M_SX2;
      pcr_pkg::SQ_M_SX2:  if (mul_done) state_nxt = pcr_pkg::SQ_M_NSYY;
      pcr_pkg::SQ_M_NSYY: if (mul_done) state_nxt = pcr_pkg::SQ_M_SY2;
      pcr_pkg::SQ_M_SY2:  if (mul_done) state_nxt = pcr_pkg::SQ_M_NSXY;
      pcr_pkg::SQ_M_NSXY: if (mul_done) state_nxt = pcr_pkg::SQ_M_SXSY;
      pcr_pkg::SQ_M_SXSY: if (mul_done) state_nxt = pcr_pkg::SQ_CLASS;
      pcr_pkg::SQ_CLASS: begin
        if (vert)       state_nxt = pcr_pkg::SQ_OUT;
        else if (horiz) state_nxt = pcr_pkg::SQ_DIV_MY;
        else            state_nxt = pcr_pkg::SQ_M_PXY;
      end
      pcr_pkg::SQ_M_PXY:  if (mul_done) state_nxt = pcr_pkg::SQ_SQRT;
      pcr_pkg::SQ_SQRT:   if (ds_stat.done) state_nxt = pcr_pkg::SQ_DIV_R;
      pcr_pkg::SQ_DIV_R:  if (ds_stat.done) state_nxt = pcr_pkg::SQ_DIV_SL;
      pcr_pkg::SQ_DIV_SL: if (ds_stat.done) state_nxt = pcr_pkg::SQ_M_SLX;
      pcr_pkg::SQ_M_SLX:  if (mul_done) state_nxt = pcr_pkg::SQ_ICN;
      pcr_pkg::SQ_ICN:    state_nxt = pcr_pkg::SQ_ICM;
      pcr_pkg::SQ_ICM:    state_nxt = pcr_pkg::SQ_ICA;
      pcr_pkg::SQ_ICA:    state_nxt = pcr_pkg::SQ_DIV_IC;
      pcr_pkg::SQ_DIV_IC: if (ds_stat.done) state_nxt = pcr_pkg::SQ_OUT;
      pcr_pkg::SQ_DIV_MY: if (ds_stat.done) state_nxt = pcr_pkg::SQ_OUT;
      pcr_pkg::SQ_OUT:    if (out_load) state_nxt = pcr_pkg::SQ_IDLE;
      default:            state_nxt = pcr_pkg::SQ_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands, unit requests.
  always_comb begin
    in_tready  = (state_r == pcr_pkg::SQ_IDLE);
    out_load   = (state_r == pcr_pkg::SQ_OUT) && (!out_valid_r || out_tready);
    mul_state  = 1'b1;
    unit_state = 1'b0;
    ma         = '0;
    mb         = '0;
    ds_num     = '0;
    ds_den     = {{(64-pcr_pkg::CNT_W){1'b0}}, n_r};
    ds_ctrl.mode = pcr_pkg::DS_DIV;
    unique case (state_r)
      pcr_pkg::SQ_M_NSXX: begin ma = {{(64-pcr_pkg::CNT_W){1'b0}}, n_r}; mb = sxx_r; end
      pcr_pkg::SQ_M_SX2:  begin ma = sx_r; mb = sx_r; end
      pcr_pkg::SQ_M_NSYY: begin ma = {{(64-pcr_pkg::CNT_W){1'b0}}, n_r}; mb = syy_r; end
      pcr_pkg::SQ_M_SY2:  begin ma = sy_r; mb = sy_r; end
      pcr_pkg::SQ_M_NSXY: begin ma = {{(64-pcr_pkg::CNT_W){1'b0}}, n_r}; mb = sxy_r; end
      pcr_pkg::SQ_M_SXSY: begin ma = sx_r; mb = sy_r; end
      pcr_pkg::SQ_M_PXY:  begin ma = cxx_r; mb = cyy_r; end
      pcr_pkg::SQ_M_SLX:  begin ma = pcr_pkg::mag64(sl_r); mb = pcr_pkg::mag64(sx_r); end
      pcr_pkg::SQ_SQRT: begin
        mul_state    = 1'b0;
        unit_state   = 1'b1;
        ds_ctrl.mode = pcr_pkg::DS_SQRT;
        ds_num       = acc_r;
        ds_den       = '0;
      end
      pcr_pkg::SQ_DIV_R: begin
        mul_state  = 1'b0;
        unit_state = 1'b1;
        ds_num     = {64'd0, mag_xy} << 30;
        ds_den     = d_r;
      end
      pcr_pkg::SQ_DIV_SL: begin
        mul_state  = 1'b0;
        unit_state = 1'b1;
        ds_num     = {64'd0, mag_xy} << pcr_pkg::FRAC_BITS;
        ds_den     = cxx_r;
      end
      pcr_pkg::SQ_DIV_IC: begin
        mul_state  = 1'b0;
        unit_state = 1'b1;
        ds_num     = w_r;
      end
      pcr_pkg::SQ_DIV_MY: begin
        mul_state  = 1'b0;
        unit_state = 1'b1;
        ds_num     = t1;
      end
      default: mul_state = 1'b0;
    endcase
    ds_ctrl.start = unit_state && !started_r && !ds_stat.busy;
  end

  // Partial products of a 64x64 multiply, one 32x32 slice per cycle.
  always_comb begin
    a_part = mcnt_r[0] ? ma[63:32] : ma[31:0];
    b_part = mcnt_r[1] ? mb[63:32] : mb[31:0];
    prod   = {32'd0, a_part} * {32'd0, b_part};
    case (pk_r) inside
      2'd0:       addend = {64'd0, prod_r};
      2'd1, 2'd2: addend = {32'd0, prod_r, 32'd0};
      default:    addend = {prod_r, 64'd0};
    endcase
  end

  always_comb begin
    sr = pcr_pkg::sat48(ds_res, 1'b0);
    case (state_r)
      pcr_pkg::SQ_DIV_SL: sr = pcr_pkg::sat48(ds_res, cxy_r[63]);
      pcr_pkg::SQ_DIV_IC: sr = pcr_pkg::sat48(ds_res, st_r);
      pcr_pkg::SQ_DIV_MY: sr = pcr_pkg::sat48(ds_res, sy_r[63]);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcr_pkg::SQ_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      mcnt_r      <= 3'd0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      syy_r       <= '0;
      sxy_r       <= '0;
      n_r         <= '0;
    end else begin
      state_r <= state_nxt;

      if (mul_state) mcnt_r <= mul_done ? 3'd0 : (mcnt_r + 3'd1);

      if (unit_state) started_r <= ds_stat.done ? 1'b0 : 1'b1;

      if (accept && !n_r[pcr_pkg::COUNT_BITS]) begin
        sx_r  <= sx_r + x64;
        sy_r  <= sy_r + y64;
        sxx_r <= sxx_r + {{(64-2*SB){pxx[2*SB-1]}}, pxx};
        syy_r <= syy_r + {{(64-2*SB){pyy[2*SB-1]}}, pyy};
        sxy_r <= sxy_r + {{(64-2*SB){pxy[2*SB-1]}}, pxy};
        n_r   <= n_r + 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        sx_r  <= '0;
        sy_r  <= '0;
        sxx_r <= '0;
        syy_r <= '0;
        sxy_r <= '0;
        n_r   <= '0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (mul_state) begin
      prod_r <= prod;
      pk_r   <= mcnt_r[1:0];
      acc_r  <= (mcnt_r == 3'd0) ? 128'd0 : (acc_r + addend);
    end
    if (out_load) begin
      out_data_r <= {7'd0, n_r[16:0], icpt_r, slope_r, r_r};
      out_user_r <= status_r;
    end
    case (state_r)
      // On the first cycle of each multiply the previous product is still in acc_r.
      pcr_pkg::SQ_M_SX2:  if (mcnt_r == 3'd0) tmp_r <= acc_r[63:0];
      pcr_pkg::SQ_M_NSYY: if (mcnt_r == 3'd0) cxx_r <= tmp_r - acc_r[63:0];
      pcr_pkg::SQ_M_SY2:  if (mcnt_r == 3'd0) tmp_r <= acc_r[63:0];
      pcr_pkg::SQ_M_NSXY: if (mcnt_r == 3'd0) cyy_r <= tmp_r - acc_r[63:0];
      pcr_pkg::SQ_M_SXSY: if (mcnt_r == 3'd0) tmp_r <= acc_r[63:0];
      pcr_pkg::SQ_CLASS: begin
        cxy_r    <= tmp_r - acc_r[63:0];
        r_r      <= '0;
        slope_r  <= '0;
        icpt_r   <= '0;
        sat_r    <= 1'b0;
        status_r <= pcr_pkg::STAT_VERT;
      end
      pcr_pkg::SQ_SQRT: begin
        if (ds_stat.done) d_r <= (ds_res[63:0] == 64'd0) ? 64'd1 : ds_res[63:0];
      end
      pcr_pkg::SQ_DIV_R: begin
        if (ds_stat.done)
          r_r <= cxy_r[63] ? (32'd0 - ds_res[31:0]) : ds_res[31:0];
      end
      pcr_pkg::SQ_DIV_SL: begin
        if (ds_stat.done) begin
          slope_r <= sr.val;
          sat_r   <= sr.sat;
          sl_r    <= {{16{sr.val[47]}}, sr.val};
        end
      end
      // Intercept numerator: sum_y*2^F - slope*sum_x, as sign and magnitude.
      pcr_pkg::SQ_ICN: w_r <= (sl_r[63] ^ sx_r[63]) ? (128'd0 - acc_r) : acc_r;
      pcr_pkg::SQ_ICM: w_r <= sy_r[63] ? (128'd0 - t1 - w_r) : (t1 - w_r);
      pcr_pkg::SQ_ICA: begin
        st_r <= w_r[127];
        w_r  <= w_r[127] ? (128'd0 - w_r) : w_r;
      end
      pcr_pkg::SQ_DIV_IC: begin
        if (ds_stat.done) begin
          icpt_r   <= sr.val;
          status_r <= (sat_r || sr.sat) ? pcr_pkg::STAT_SAT : pcr_pkg::STAT_NORMAL;
        end
      end
      pcr_pkg::SQ_DIV_MY: begin
        if (ds_stat.done) begin
          icpt_r   <= sr.val;
          status_r <= sr.sat ? pcr_pkg::STAT_SAT : pcr_pkg::STAT_HORIZ;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ hw/rtl/pcr_divsqrt.sv @@
// ----------------------------------------------------------------------------
// Shared divide and square root unit
// Restoring radix-2 divide (rounded) and restoring integer square root.
// ----------------------------------------------------------------------------
module pcr_divsqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  pcr_pkg::ds_ctrl_t ctrl,
  input  logic [127:0]      num,
  input  logic [63:0]       den,
  output pcr_pkg::ds_stat_t stat,
  output logic [127:0]      result
);

  pcr_pkg::ds_state_t state_r, state_nxt;
  pcr_pkg::ds_mode_t  mode_r;
  logic [127:0] num_r;
  logic [63:0]  den_r;
  logic [64:0]  rem_r;
  logic [127:0] q_r;
  logic [6:0]   cnt_r;
  logic         done_r;

  logic [66:0] rem_sh;
  logic [66:0] trial;
  logic [66:0] diff;
  logic        ge;

  // One compare and subtract serves both operations.
  always_comb begin
    if (mode_r == pcr_pkg::DS_SQRT) begin
      rem_sh = {rem_r, num_r[127:126]};
      trial  = {1'b0, q_r[63:0], 2'b01};
    end else begin
      rem_sh = {2'b00, rem_r[63:0], num_r[127]};
      trial  = {3'b000, den_r};
    end
    diff = rem_sh - trial;
    ge   = (rem_sh >= trial);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcr_pkg::DS_IDLE:  if (ctrl.start) state_nxt = pcr_pkg::DS_RUN;
      pcr_pkg::DS_RUN:   if (cnt_r == 7'd0) state_nxt = pcr_pkg::DS_ROUND;
      pcr_pkg::DS_ROUND: state_nxt = pcr_pkg::DS_IDLE;
      default:           state_nxt = pcr_pkg::DS_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state_r != pcr_pkg::DS_IDLE);
    stat.done = done_r;
    result    = q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcr_pkg::DS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == pcr_pkg::DS_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      pcr_pkg::DS_IDLE: begin
        if (ctrl.start) begin
          mode_r <= ctrl.mode;
          num_r  <= num;
          den_r  <= den;
          rem_r  <= '0;
          q_r    <= '0;
          cnt_r  <= (ctrl.mode == pcr_pkg::DS_SQRT) ? 7'd63 : 7'd127;
        end
      end
      pcr_pkg::DS_RUN: begin
        rem_r <= ge ? diff[64:0] : rem_sh[64:0];
        q_r   <= {q_r[126:0], ge};
        num_r <= (mode_r == pcr_pkg::DS_SQRT) ? {num_r[125:0], 2'b00}
                                              : {num_r[126:0], 1'b0};
        cnt_r <= cnt_r - 7'd1;
      end
      pcr_pkg::DS_ROUND: begin
        // Round to nearest, ties up, on the quotient only.
        if ((mode_r == pcr_pkg::DS_DIV) && (rem_r[63:0] >= (den_r - rem_r[63:0])))
          q_r <= q_r + 128'd1;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/pcr_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker for the correlation and regression block
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "pearson_correlation_regression_top_assert.svh"

module pcr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [pcr_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pcr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser
);

  // A stalled result holds.
  `PCR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A pair inside a set never stalls the stream.
  `PCR_ASSERT_NXT(a_mid_ready, in_tvalid && in_tready && !in_tlast, in_tready, "ready dropped inside a set")

  // The closing pair starts the computation, so the input must stall.
  `PCR_ASSERT_NXT(a_last_busy, in_tvalid && in_tready && in_tlast, !in_tready, "ready held after last pair")

  // A vertical line or point reports zero r, slope and intercept.
  `PCR_ASSERT_NOW(a_vert_zero, out_tvalid && (out_tuser == pcr_pkg::STAT_VERT), out_tdata[127:0] == 128'd0, "nonzero result on vertical status")

endmodule

bind pearson_correlation_regression_top pcr_checker u_pcr_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the correlation and regression block
// Streams sample pairs with random gaps and checks every result against a
// predictor of r, slope, intercept, count and status.
// ----------------------------------------------------------------------------
module tb;

  // One finished data set as the block reports it.
  typedef struct {
    logic [31:0] corr;
    logic [47:0] slope;
    logic [47:0] icpt;
    logic [16:0] count;
    logic [1:0]  status;
  } fit_t;

  // One row of the directed stimulus. A row with a typed result uses it in
  // place of the prediction.
  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    bit          last;
    bit          typed;
    fit_t        fit;
  } row_t;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  FULL_PAIRS   = 1 << pcr_pkg::COUNT_BITS;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [pcr_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [pcr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                     out_tuser;

  // Running sums of the open data set, wrapping at 64 bits.
  logic [63:0] acc_x, acc_y, acc_xx, acc_yy, acc_xy, acc_n;
  fit_t        fits_due[$];
  int          errors;
  int          cycles;
  bit          gaps_on;
  bit          stall_on;

  pearson_correlation_regression_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic [63:0] absval(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Unsigned quotient rounded to nearest, halves rounded up.
  function automatic logic [127:0] div_round(input logic [127:0] num,
                                             input logic [63:0] den);
    logic [127:0] q, r, d;
    d = {64'd0, den};
    q = num / d;
    r = num % d;
    if (r >= d - r) q = q + 128'd1;
    return q;
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] p);
    logic [63:0]  r, c;
    logic [127:0] cc;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      cc = {64'd0, c} * {64'd0, c};
      if (cc <= p) r = c;
    end
    return r;
  endfunction

  // Applies the sign to a magnitude and clamps to the 48-bit range; the
  // returned value is sign-extended to 64 bits.
  function automatic logic [63:0] clamp48(input logic [127:0] mag, input logic neg,
                                          inout bit clipped);
    logic [63:0] lim, m;
    lim = neg ? pcr_pkg::LIM48 : pcr_pkg::LIM48 - 64'd1;
    m   = mag[63:0];
    if (mag[127:64] != 64'd0 || mag[63:0] > lim) begin
      clipped = 1'b1;
      m       = lim;
    end
    return neg ? (64'd0 - m) : m;
  endfunction

  // Closes the open data set and works out its line fit.
  function automatic fit_t line_fit();
    fit_t         f;
    logic [63:0]  sxx, syy, sxy, a, d, sl, slm;
    logic [127:0] t1, t2, t, q;
    logic         sn, st;
    bit           clipped;
    clipped = 1'b0;
    f.corr  = '0;
    f.slope = '0;
    f.icpt  = '0;
    f.count = acc_n[16:0];
    sxx = acc_n * acc_xx - acc_x * acc_x;
    syy = acc_n * acc_yy - acc_y * acc_y;
    sxy = acc_n * acc_xy - acc_x * acc_y;
    if (sxx == 64'd0 || sxx[63]) begin
      f.status = pcr_pkg::STAT_VERT;
    end else if (syy == 64'd0 || syy[63]) begin
      q        = div_round({64'd0, absval(acc_y)} << pcr_pkg::FRAC_BITS, acc_n);
      f.icpt   = 48'(clamp48(q, acc_y[63], clipped));
      f.status = clipped ? pcr_pkg::STAT_SAT : pcr_pkg::STAT_HORIZ;
    end else begin
      a  = absval(sxy);
      sn = sxy[63];
      d  = root_floor({64'd0, sxx} * {64'd0, syy});
      if (d == 64'd0) d = 64'd1;
      q      = div_round({64'd0, a} << 30, d);
      f.corr = sn ? (32'd0 - q[31:0]) : q[31:0];
      sl      = clamp48(div_round({64'd0, a} << pcr_pkg::FRAC_BITS, sxx), sn, clipped);
      f.slope = sl[47:0];
      slm = absval(sl);
      t1  = {64'd0, absval(acc_y)} << pcr_pkg::FRAC_BITS;
      t2  = {64'd0, slm} * {64'd0, absval(acc_x)};
      if (acc_y[63]) t1 = 128'd0 - t1;
      if (sl[63] ^ acc_x[63]) t2 = 128'd0 - t2;
      t  = t1 - t2;
      st = t[127];
      if (st) t = 128'd0 - t;
      f.icpt   = 48'(clamp48(div_round(t, acc_n), st, clipped));
      f.status = clipped ? pcr_pkg::STAT_SAT : pcr_pkg::STAT_NORMAL;
    end
    return f;
  endfunction

  function automatic logic [63:0] widen(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Adds one accepted pair to the sums; a closing pair yields its expected
  // fit, or the typed one when the row gives it.
  task automatic absorb(input logic [15:0] x, input logic [15:0] y, input bit last,
                        input bit typed, input fit_t given);
    logic [63:0] xv, yv;
    xv = widen(x);
    yv = widen(y);
    if (acc_n < 64'(FULL_PAIRS)) begin
      acc_x  = acc_x + xv;
      acc_y  = acc_y + yv;
      acc_xx = acc_xx + xv * xv;
      acc_yy = acc_yy + yv * yv;
      acc_xy = acc_xy + xv * yv;
      acc_n  = acc_n + 64'd1;
    end
    if (last) begin
      fits_due.push_back(typed ? given : line_fit());
      acc_x  = '0;
      acc_y  = '0;
      acc_xx = '0;
      acc_yy = '0;
      acc_xy = '0;
      acc_n  = '0;
    end
  endtask

  function automatic int gap_len();
    int p;
    p = int'($urandom_range(99));
    if (p < 70) return 0;
    if (p < 95) return int'($urandom_range(3, 1));
    return int'($urandom_range(60, 10));
  endfunction

  // Presents one request from a falling edge and holds it until taken.
  task automatic send(input logic [15:0] x, input logic [15:0] y, input bit last,
                      input bit typed, input fit_t given);
    int g;
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {y, x};
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    absorb(x, y, last, typed, given);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Random sink stalls, with calm stretches when stalling is off.
  always @(negedge clk) begin
    if (!stall_on) out_tready <= 1'b1;
    else out_tready <= (gap_len() == 0);
  end

  always @(posedge clk) begin
    fit_t        e;
    logic [31:0] r;
    logic [47:0] sl, ic;
    logic [16:0] n;
    if (rst_n && out_tvalid && out_tready) begin
      r  = out_tdata[31:0];
      sl = out_tdata[79:32];
      ic = out_tdata[127:80];
      n  = out_tdata[144:128];
      if (fits_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result r=%h count=%0d", r, n);
      end else begin
        e = fits_due.pop_front();
        if (r !== e.corr || sl !== e.slope || ic !== e.icpt || n !== e.count ||
            out_tuser !== e.status || out_tdata[151:145] !== '0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp r=%h sl=%h ic=%h n=%0d st=%0d got r=%h sl=%h ic=%h n=%0d st=%0d",
                     e.corr, e.slope, e.icpt, e.count, e.status,
                     r, sl, ic, n, out_tuser);
        end
      end
    end
  end

  function automatic row_t pair(input int x, input int y, input bit last);
    row_t w;
    w.x     = x[15:0];
    w.y     = y[15:0];
    w.last  = last;
    w.typed = 1'b0;
    w.fit   = '{default: '0};
    return w;
  endfunction

  function automatic row_t closing(input int x, input int y, input logic [31:0] r,
                                   input logic [47:0] sl, input logic [47:0] ic,
                                   input int n, input logic [1:0] st);
    row_t w;
    w       = pair(x, y, 1'b1);
    w.typed = 1'b1;
    w.fit   = '{r, sl, ic, n[16:0], st};
    return w;
  endfunction

  initial begin
    row_t        rows[$];
    int          sent, len, kind;
    bit          drained;
    logic [15:0] x, y, base_x, base_y, step;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    errors     = 0;
    cycles     = 0;
    gaps_on    = 1'b0;
    stall_on   = 1'b0;
    drained    = 1'b0;
    acc_x = '0; acc_y = '0; acc_xx = '0; acc_yy = '0; acc_xy = '0; acc_n = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A single point right after reset counts as a vertical line.
    rows.push_back(closing(5, 7, 0, 0, 0, 1, pcr_pkg::STAT_VERT));
    // The two extreme corners lie on y = x: r is one and the slope one.
    rows.push_back(pair(-32768, -32768, 0));
    rows.push_back(closing(32767, 32767, 32'h4000_0000, 48'h1_0000, 0, 2,
                           pcr_pkg::STAT_NORMAL));
    // Horizontal line at y = 5.
    rows.push_back(pair(0, 5, 0));
    rows.push_back(closing(1, 5, 0, 0, 48'h5_0000, 2, pcr_pkg::STAT_HORIZ));
    // Vertical line at the negative extreme.
    rows.push_back(pair(-32768, 100, 0));
    rows.push_back(closing(-32768, -100, 0, 0, 0, 2, pcr_pkg::STAT_VERT));
    // Steepest slope the samples allow, then a falling line.
    rows.push_back(pair(0, -32768, 0));
    rows.push_back(pair(1, 32767, 1));
    rows.push_back(pair(32767, -32768, 0));
    rows.push_back(pair(-32768, 32767, 0));
    rows.push_back(pair(1, 3, 1));
    // Horizontal line at the negative extreme of y.
    rows.push_back(pair(-5, -32768, 0));
    rows.push_back(pair(9, -32768, 0));
    rows.push_back(pair(12345, -32768, 1));
    // Scattered set with every bit of both fields flipping.
    rows.push_back(pair(16'h5555, 16'haaaa, 0));
    rows.push_back(pair(16'haaaa, 16'h5555, 0));
    rows.push_back(pair(0, 0, 0));
    rows.push_back(pair(-1, -1, 1));

    foreach (rows[i]) send(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, rows[i].fit);

    // Random sets: mostly small, shaped as lines, flat runs, vertical runs and
    // plain noise.
    sent = 0;
    while (sent < 900) begin
      if ($urandom_range(9) == 0) begin
        gaps_on  = 1'($urandom_range(1));
        stall_on = 1'($urandom_range(1));
      end
      len    = ($urandom_range(9) == 0) ? int'($urandom_range(40, 2))
                                        : int'($urandom_range(8, 1));
      kind   = int'($urandom_range(4));
      base_x = 16'($urandom);
      base_y = 16'($urandom);
      step   = 16'($urandom_range(7, 1));
      for (int k = 0; k < len; k++) begin
        x = 16'($urandom);
        y = 16'($urandom);
        case (kind)
          0: begin
            x = base_x;
          end
          1: begin
            y = base_y;
          end
          2: begin
            x = base_x + k[15:0] * step;
            y = base_y - k[15:0] * step + 16'($urandom_range(3));
          end
          3: begin
            x = 16'($urandom_range(15));
            y = 16'($urandom_range(15)) - 16'd8;
          end
          default: ;
        endcase
        send(x, y, k == len - 1, 1'b0, '{default: '0});
        sent++;
      end
      // Once, hold the sender until the block has answered everything so far.
      if (!drained && sent > 450) begin
        drained = 1'b1;
        while (fits_due.size() != 0) @(negedge clk);
      end
    end

    while (fits_due.size() != 0) @(negedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
